@@ src/kpsfa_pkg.sv @@
package kpsfa_pkg;

  localparam int WORD_W    = 16;
  localparam int LINE_BITS = 8;
  localparam int MAP_W     = 64;
  localparam int CNT_W     = 4;
  localparam int ADDR_W    = 1;

  // register indexes
  localparam logic [ADDR_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [ADDR_W-1:0] REG_COL_COUNT = 1'b1;

  // low n bits set, all eight at n >= LINE_BITS
  function automatic logic [LINE_BITS-1:0] low_mask8(input logic [CNT_W-1:0] n);
    logic [LINE_BITS-1:0] m;
    m = '0;
    for (int i = 0; i < LINE_BITS; i++) begin
      m[i] = (CNT_W'(i) < n);
    end
    return m;
  endfunction

endpackage

@@ src/keypad_scan_frame_accumulator_unit.sv @@
// Channel  Signals                                   Dir  Notes
// in       in_valid/in_ready, scan_word[15:0]        in   row one-hot [15:8], cols [7:0]
// out      out_valid/out_ready, key_map[63:0],       out  one result item per input item
//          map_changed, hold_timer
// cfg      cfg_we, cfg_addr[0], cfg_data[3:0]        in   0 row_count, 1 col_count
//
// One item per cycle sustained while the output is not stalled. An accepted item
// is registered in the input register, then the key bitmap logic runs and loads
// the result register, which raises out_valid. Sync reset (rst) clears both
// stages and all bitmaps; row_count/col_count return to 8. A stalled output
// holds the result register; the input register still fills, then in_ready drops.
module keypad_scan_frame_accumulator_unit
  import kpsfa_pkg::*;
#(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [WORD_W-1:0]   scan_word,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [MAP_W-1:0]    key_map,
  output logic                map_changed,
  output logic                hold_timer,
  input  logic                cfg_we,
  input  logic [ADDR_W-1:0]   cfg_addr,
  input  logic [CNT_W-1:0]    cfg_data
);

  localparam int ROW_W = $clog2(LINE_BITS);
  localparam int OFS_W = ROW_W + CNT_W;

  // configuration
  logic [CNT_W-1:0] row_count;
  logic [CNT_W-1:0] col_count;

  // input stage
  logic              s1_valid;
  logic [WORD_W-1:0] s1_word;

  // scan state
  logic [WORD_W-1:0] prev_scan;
  logic [MAP_W-1:0]  frame_keys;
  logic [MAP_W-1:0]  pending_keys;

  logic              advance;
  logic [CNT_W-1:0]  nrows;
  logic [CNT_W-1:0]  ncols;
  logic [LINE_BITS-1:0] rows;
  logic [LINE_BITS-1:0] cols;
  logic [ROW_W-1:0]  row;
  logic [OFS_W-1:0]  offset;
  logic [MAP_W-1:0]  add_keys;
  logic              boundary;
  logic [MAP_W-1:0]  frame_keys_next;
  logic [MAP_W-1:0]  pending_keys_next;

  // result register drains or is empty -> input stage can move on
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= CNT_W'(8);
      col_count <= CNT_W'(8);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ROW_COUNT: row_count <= cfg_data;
        REG_COL_COUNT: col_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word <= scan_word;
    end
  end

  // saturate counts at the build maxima
  assign nrows = (row_count > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : row_count;
  assign ncols = (col_count > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : col_count;

  assign rows = s1_word[WORD_W-1 -: LINE_BITS] & low_mask8(nrows);
  assign cols = s1_word[LINE_BITS-1:0] & low_mask8(ncols);

  // lowest active row wins
  always_comb begin
    row = '0;
    for (int i = LINE_BITS - 1; i >= 0; i--) begin
      if (rows[i]) begin
        row = ROW_W'(i);
      end
    end
  end

  assign offset   = OFS_W'(row) * OFS_W'(ncols);
  // bits shifted past the top of the map are dropped
  assign add_keys = (rows != '0) ? (MAP_W'(cols) << offset) : '0;
  assign boundary = (prev_scan >= s1_word);

  always_comb begin
    frame_keys_next   = boundary ? pending_keys : frame_keys;
    pending_keys_next = boundary ? '0 : pending_keys;
    if (s1_word == '0) begin
      // release clears everything
      frame_keys_next   = '0;
      pending_keys_next = '0;
    end else begin
      pending_keys_next = pending_keys_next | add_keys;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_scan    <= '0;
      frame_keys   <= '0;
      pending_keys <= '0;
    end else if (advance) begin
      prev_scan    <= s1_word;
      frame_keys   <= frame_keys_next;
      pending_keys <= pending_keys_next;
    end
  end

  // reported map always tracks frame_keys after a step
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      key_map     <= frame_keys_next;
      map_changed <= (frame_keys_next != frame_keys);
      hold_timer  <= (frame_keys_next != '0);
    end
  end

endmodule

@@ src/kpsfa_checker.sv @@
module kpsfa_checker
  import kpsfa_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [MAP_W-1:0]  key_map,
  input logic              map_changed,
  input logic              hold_timer
);

  logic [MAP_W-1:0] last_map;

  // last delivered map; reset value of the reported map is zero
  always_ff @(posedge clk) begin
    if (rst) begin
      last_map <= '0;
    end else if (out_valid && out_ready) begin
      last_map <= key_map;
    end
  end

  a_hold_map: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hold_timer == (key_map != '0)))
    else $error("hold_timer disagrees with key_map");

  a_changed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (map_changed == (key_map != last_map)))
    else $error("map_changed disagrees with previous item");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(key_map))
    else $error("stalled result item changed");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid after reset");

  a_accept_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && out_valid && !out_ready |=> !in_ready || !out_valid || out_ready)
    else $error("input stage overran a stalled output");

endmodule

bind keypad_scan_frame_accumulator_unit kpsfa_checker u_kpsfa_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .key_map     (key_map),
  .map_changed (map_changed),
  .hold_timer  (hold_timer)
);

@@ tb/tb_keypad_scan_frame_accumulator_unit.sv @@
`default_nettype none

module tb_keypad_scan_frame_accumulator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import kpsfa_pkg::*;

  // cycles with no item moving on either channel before the run is called hung
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 60;   // long receiver hold-off
  localparam int N_PHASES    = 11;
  localparam int PHASE_ITEMS = 165;
  localparam int DIR_N       = 23;

  typedef struct packed {
    logic [MAP_W-1:0] map;
    logic             changed;
    logic             hold;
  } key_result_t;

  // one row of the directed table; typed rows carry their own expectation
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              typed;
    key_result_t       res;
  } dir_row_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [WORD_W-1:0] scan_word = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [MAP_W-1:0]  key_map;
  logic              map_changed;
  logic              hold_timer;
  logic              cfg_we    = 1'b0;
  logic [ADDR_W-1:0] cfg_addr  = '0;
  logic [CNT_W-1:0]  cfg_data  = '0;

  keypad_scan_frame_accumulator_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .scan_word   (scan_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .key_map     (key_map),
    .map_changed (map_changed),
    .hold_timer  (hold_timer),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Key bitmap predictor: own copy of the count registers and the bitmaps.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]  rows_reg = CNT_W'(8);
  logic [CNT_W-1:0]  cols_reg = CNT_W'(8);
  logic [WORD_W-1:0] last_scan;
  logic [MAP_W-1:0]  frame_map;
  logic [MAP_W-1:0]  pend_map;
  logic [MAP_W-1:0]  shown_map;

  key_result_t exp_results[$];

  // low n lanes of a row/column byte, all of them from 8 up
  function automatic logic [LINE_BITS-1:0] lane_mask(input int n);
    return (n >= LINE_BITS) ? '1 : LINE_BITS'((1 << n) - 1);
  endfunction

  function automatic key_result_t predict_scan(input logic [WORD_W-1:0] w);
    key_result_t      r;
    int               nr;
    int               nc;
    int               row;
    logic [LINE_BITS-1:0] rows;
    logic [LINE_BITS-1:0] cols;
    nr = (rows_reg > 8) ? 8 : int'(rows_reg);   // saturate above max
    nc = (cols_reg > 8) ? 8 : int'(cols_reg);
    // word not above the previous one closes the frame
    if (last_scan >= w) begin
      frame_map = pend_map;
      pend_map  = '0;
    end
    if (w == '0) begin
      // release: drop everything
      frame_map = '0;
      pend_map  = '0;
    end else begin
      rows = w[15:8] & lane_mask(nr);
      cols = w[7:0] & lane_mask(nc);
      if (rows != '0) begin
        row = 0;
        while (!rows[row]) row++;             // lowest active row wins
        for (int c = 0; c < LINE_BITS; c++) begin
          if (cols[c] && (row * nc + c) < MAP_W) pend_map[row * nc + c] = 1'b1;
        end
      end
    end
    r.changed = (shown_map != frame_map);
    shown_map = frame_map;
    r.map     = shown_map;
    r.hold    = (frame_map != '0);
    last_scan = w;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  logic hold_req = 1'b0;   // asks the receiver for one long hold-off
  logic calm     = 1'b0;   // no idling on either side
  int   n_items  = 0;
  int   n_cfg    = 0;

  // scanner walk: rows in order, columns held per row, changing now and then
  logic [LINE_BITS-1:0] held_cols [LINE_BITS];
  int                   scan_row;
  int                   scan_rows;
  logic [WORD_W-1:0]    prev_sent;

  function automatic logic [WORD_W-1:0] next_scan_word();
    int                p;
    logic [WORD_W-1:0] w;
    p = $urandom_range(0, 99);
    if (p < 6) begin
      w = '0;
      if ($urandom_range(0, 1) == 1) begin
        foreach (held_cols[i]) held_cols[i] = '0;
      end
    end else if (p < 16) begin
      w = WORD_W'($urandom);
    end else if (p < 22) begin
      w = prev_sent;                          // repeat closes a frame
    end else if (p < 28) begin
      w = {LINE_BITS'($urandom), LINE_BITS'($urandom)};
    end else begin
      if ($urandom_range(0, 15) == 0) begin
        held_cols[scan_row] = ($urandom_range(0, 2) == 0) ? '0 : LINE_BITS'($urandom);
      end
      w = {LINE_BITS'(1 << scan_row), held_cols[scan_row]};
      scan_row = (scan_row + 1) % scan_rows;
    end
    prev_sent = w;
    return w;
  endfunction

  // offer one item, hold it until taken, then maybe idle
  task automatic send_scan(input logic [WORD_W-1:0] w, input logic typed,
                           input key_result_t typed_res);
    key_result_t r;
    in_valid  <= 1'b1;
    scan_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = predict_scan(w);
    exp_results.push_back(typed ? typed_res : r);
    n_items++;
    if (!calm && !hold_req && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // both count registers, back to back; block is idle here
  task automatic set_counts(input logic [CNT_W-1:0] nr, input logic [CNT_W-1:0] nc);
    cfg_we   <= 1'b1;
    cfg_addr <= REG_ROW_COUNT;
    cfg_data <= nr;
    @(posedge clk);
    rows_reg = nr;
    cfg_addr <= REG_COL_COUNT;
    cfg_data <= nc;
    @(posedge clk);
    cols_reg = nc;
    cfg_we   <= 1'b0;
    @(posedge clk);
    n_cfg++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, one long hold-off on request, none when calm
  // ---------------------------------------------------------------------------
  initial begin
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (calm || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  int n_errs  = 0;
  int n_seen  = 0;
  int n_chg   = 0;
  int n_holds = 0;

  always @(posedge clk) begin
    key_result_t e;
    if (!rst && out_valid && out_ready) begin
      n_seen++;
      if (map_changed) n_chg++;
      if (hold_timer) n_holds++;
      if (exp_results.size() == 0) begin
        n_errs++;
        if (n_errs <= 10)
          $display("ERROR: result with nothing expected: map=%h chg=%b hold=%b",
                   key_map, map_changed, hold_timer);
      end else begin
        e = exp_results.pop_front();
        if (key_map !== e.map || map_changed !== e.changed || hold_timer !== e.hold) begin
          n_errs++;
          if (n_errs <= 10)
            $display("ERROR: result %0d: exp map=%h chg=%b hold=%b, got map=%h chg=%b hold=%b",
                     n_seen, e.map, e.changed, e.hold, key_map, map_changed, hold_timer);
        end
      end
    end
  end

  // watchdog on channel activity
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  dir_row_t dir_tab [DIR_N];

  // register settings per random phase: reset value, minimum, zero, above max
  logic [CNT_W-1:0] ph_rows [N_PHASES];
  logic [CNT_W-1:0] ph_cols [N_PHASES];

  initial begin
    dir_tab = '{
      '{16'h0000, 1'b1, '{64'h0, 1'b0, 1'b0}},  // first item after reset
      '{16'h0101, 1'b0, '0},
      '{16'h0280, 1'b0, '0},
      '{16'h8001, 1'b0, '0},                    // top row
      '{16'h80FF, 1'b0, '0},                    // top row, all columns
      '{16'h0101, 1'b0, '0},                    // drop back: frame boundary
      '{16'h0101, 1'b0, '0},                    // equal word: boundary too
      '{16'hFFFF, 1'b0, '0},                    // several rows: lowest one
      '{16'hFF00, 1'b0, '0},                    // rows, no columns
      '{16'h00FF, 1'b0, '0},                    // columns, no row
      '{16'h0000, 1'b0, '0},                    // release
      '{16'h0000, 1'b1, '{64'h0, 1'b0, 1'b0}},  // release again: nothing left
      '{16'h0301, 1'b0, '0},
      '{16'h4020, 1'b0, '0},
      '{16'h2040, 1'b0, '0},
      '{16'h1008, 1'b0, '0},
      '{16'h0804, 1'b0, '0},
      '{16'h0402, 1'b0, '0},
      '{16'h0210, 1'b0, '0},
      '{16'h0180, 1'b0, '0},
      '{16'h0101, 1'b0, '0},
      '{16'hFFFF, 1'b0, '0},
      '{16'h0000, 1'b0, '0}
    };
    ph_rows = '{4'd8, 4'd1, 4'd0, 4'd8, 4'd15, 4'd3, 4'd5, 4'd9, 4'd2, 4'd0, 4'd8};
    ph_cols = '{4'd8, 4'd1, 4'd8, 4'd0, 4'd15, 4'd7, 4'd3, 4'd12, 4'd8, 4'd0, 4'd8};
    ph_rows[9] = CNT_W'($urandom_range(0, 15));
    ph_cols[9] = CNT_W'($urandom_range(0, 15));

    last_scan = '0;
    frame_map = '0;
    pend_map  = '0;
    shown_map = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed walk at reset counts
    for (int i = 0; i < DIR_N; i++) begin
      send_scan(dir_tab[i].word, dir_tab[i].typed, dir_tab[i].res);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_results();                       // sender waits for every result
      set_counts(ph_rows[ph], ph_cols[ph]);
      if (ph == N_PHASES - 1) calm = 1'b1;
      scan_rows = (ph_rows[ph] == 0) ? 1 : ((ph_rows[ph] > 8) ? 8 : int'(ph_rows[ph]));
      if (scan_rows < 8 && $urandom_range(0, 4) == 0) scan_rows++;  // reach masked rows
      scan_row  = 0;
      prev_sent = '0;
      foreach (held_cols[i]) held_cols[i] = LINE_BITS'($urandom);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 1 && k == 20) hold_req = 1'b1;   // fill the pipe, stall input
        send_scan(next_scan_word(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (4) @(posedge clk);

    $display("Run: %0d scan items, %0d results checked over %0d count settings",
             n_items, n_seen, n_cfg + 1);
    $display("     %0d map changes and %0d hold-timer requests observed",
             n_chg, n_holds);
    if (n_errs == 0 && exp_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Mismatches: %0d, results still outstanding: %0d",
               n_errs, exp_results.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
src/kpsfa_pkg.sv
src/keypad_scan_frame_accumulator_unit.sv
src/kpsfa_checker.sv
tb/tb_keypad_scan_frame_accumulator_unit.sv
